### design/rssi_sorted_neighbor_table_assert.svh
// Assertion macros for the RSSI-sorted neighbor table.
`ifndef RSSI_SORTED_NEIGHBOR_TABLE_ASSERT_SVH
`define RSSI_SORTED_NEIGHBOR_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RSNT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RSNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/rsnt_pkg.sv
// Shared types and constants for the RSSI-sorted neighbor table.
`timescale 1ns / 1ps
`default_nettype none
package rsnt_pkg;

  localparam int TABLE_ENTRIES = 5;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W = 16;
  localparam int STR_W = 16;
  localparam int POS_W = 3;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W = OUT_TDATA_W - POS_W - ADDR_W - STR_W;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_REPLACED = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef struct packed {
    logic [STR_W-1:0]  strength;
    logic [ADDR_W-1:0] addr;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  position;
    logic [ADDR_W-1:0] addr;
    logic [STR_W-1:0]  strength;
    logic              last;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage
`default_nettype wire

### design/rsnt_queue.sv
// Front end: input request queue that decouples the stream from the table engine.
`timescale 1ns / 1ps
`default_nettype none
module rsnt_queue (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [rsnt_pkg::IN_TDATA_W-1:0]     s_tdata,
  output rsnt_pkg::queue_head_t               head,
  input  wire                                 pop
);
  import rsnt_pkg::*;

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              do_pop;

  assign s_tready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign do_pop   = pop && (fill != '0);

  assign head.valid = (fill != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_t'(s_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### design/rsnt_engine.sv
// Back end: table lookup, update, move-to-front reorder and result emission.
`timescale 1ns / 1ps
`default_nettype none
module rsnt_engine (
  input  wire                    clk,
  input  wire                    rst,
  input  rsnt_pkg::queue_head_t  head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output rsnt_pkg::result_t      out
);
  import rsnt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_SORT,
    S_EMIT
  } state_t;

  state_t             state;
  item_t              cur;
  status_t            cur_status;
  logic [ADDR_W-1:0]  taddr [TABLE_ENTRIES];
  logic [STR_W-1:0]   tstr  [TABLE_ENTRIES];
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;

  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic               sort_hit;
  logic [IDX_W-1:0]   sort_pos;
  logic               rotate;
  logic [CNT_W-1:0]   idx_next;

  assign pop = (state == S_IDLE) && head.valid;

  // Lowest matching position wins, as in a forward search.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < count) && (taddr[i] == cur.addr)) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  // First adjacent pair whose later entry is strictly stronger.
  always_comb begin
    sort_hit = 1'b0;
    sort_pos = '0;
    for (int i = TABLE_ENTRIES - 2; i >= 0; i--) begin
      if ((CNT_W'(i + 1) < count) && (tstr[i + 1] > tstr[i])) begin
        sort_hit = 1'b1;
        sort_pos = IDX_W'(i + 1);
      end
    end
  end

  // During emission the live entries rotate left by one per result, so the
  // head entry is always the next one out and the table ends up unchanged.
  assign rotate   = ((state == S_SORT) && !sort_hit) ||
                    ((state == S_EMIT) && out_valid && out_ready && !out.last);
  assign idx_next = idx + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && head.valid) begin
      cur <= head.item;
    end

    if (state == S_APPLY) begin
      if (found) begin
        tstr[found_idx] <= cur.strength;
      end else if (count < CNT_W'(TABLE_ENTRIES)) begin
        taddr[count[IDX_W-1:0]] <= cur.addr;
        tstr[count[IDX_W-1:0]]  <= cur.strength;
      end else if (tstr[TABLE_ENTRIES-1] < cur.strength) begin
        taddr[TABLE_ENTRIES-1] <= cur.addr;
        tstr[TABLE_ENTRIES-1]  <= cur.strength;
      end
    end else if (state == S_SORT && sort_hit) begin
      taddr[0] <= taddr[sort_pos];
      tstr[0]  <= tstr[sort_pos];
      for (int k = 1; k < TABLE_ENTRIES; k++) begin
        if (IDX_W'(k) <= sort_pos) begin
          taddr[k] <= taddr[k - 1];
          tstr[k]  <= tstr[k - 1];
        end
      end
    end else if (rotate) begin
      for (int k = 0; k < TABLE_ENTRIES - 1; k++) begin
        if (CNT_W'(k + 1) < count) begin
          taddr[k] <= taddr[k + 1];
          tstr[k]  <= tstr[k + 1];
        end
      end
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (CNT_W'(k + 1) == count) begin
          taddr[k] <= taddr[0];
          tstr[k]  <= tstr[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (found) begin
            cur_status <= ST_UPDATED;
            state      <= S_SORT;
          end else if (count < CNT_W'(TABLE_ENTRIES)) begin
            cur_status <= ST_INSERTED;
            count      <= count + CNT_W'(1);
            state      <= S_SORT;
          end else if (tstr[TABLE_ENTRIES-1] < cur.strength) begin
            cur_status <= ST_REPLACED;
            state      <= S_SORT;
          end else begin
            out.status   <= ST_REJECTED;
            out.position <= '0;
            out.addr     <= '0;
            out.strength <= '0;
            out.last     <= 1'b1;
            out_valid    <= 1'b1;
            state        <= S_EMIT;
          end
        end
        S_SORT: begin
          if (!sort_hit) begin
            out.status   <= cur_status;
            out.position <= '0;
            out.addr     <= taddr[0];
            out.strength <= tstr[0];
            out.last     <= (count == CNT_W'(1));
            out_valid    <= 1'b1;
            idx          <= CNT_W'(1);
            state        <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_valid && out_ready) begin
            if (out.last) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              out.position <= POS_W'(idx);
              out.addr     <= taddr[0];
              out.strength <= tstr[0];
              out.last     <= (idx_next == count);
              idx          <= idx_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### design/rssi_sorted_neighbor_table.sv
// Top level of the RSSI-sorted neighbor table with stream request ports.
// The idle engine pops the queue head and applies the request (update, insert, replace or
// reject), then makes move-to-front steps until sorted by strength and emits every entry.
// A rejected request skips the reorder and emits one empty result. A new request is popped
// only after the last result is accepted; the input queue holds four requests meanwhile.
// Reset clears the queue, the entry count and the output valid; entries are undefined.
`timescale 1ns / 1ps
`default_nettype none
module rssi_sorted_neighbor_table (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // s_tdata: sender_addr [15:0], signal_strength [31:16]
  input  wire  [rsnt_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // m_tdata: entry_position [2:0], entry_addr [18:3], entry_strength [34:19], zeros above
  output logic [rsnt_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // m_tuser: status [1:0]
  output logic [1:0]                          m_tuser,
  output logic                                m_tlast
);
  import rsnt_pkg::*;

  queue_head_t head;
  logic        pop;
  result_t     res;

  rsnt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .head     (head),
    .pop      (pop)
  );

  rsnt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out       (res)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, res.strength, res.addr, res.position};
  assign m_tuser = res.status;
  assign m_tlast = res.last;

`include "rssi_sorted_neighbor_table_assert.svh"

  `RSNT_ASSERT_NOW(a_reject_single, m_tvalid && (m_tuser == ST_REJECTED), m_tlast && (m_tdata == '0), "rejected request must be one empty last result")
  `RSNT_ASSERT_NEXT(a_position_steps, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[2:0] == 3'($past(m_tdata[2:0]) + 3'd1)), "entry positions must advance by one")
  `RSNT_ASSERT_NEXT(a_strength_order, m_tvalid && m_tready && !m_tlast, m_tdata[34:19] <= $past(m_tdata[34:19]), "emitted entries must not increase in strength")

endmodule
`default_nettype wire
